### rtl/core/svdpi_pkg.sv
// ----------------------------------------------------------------------------
// svdpi_pkg
// Shared types and constants of the SVD pseudo-inverse solver.
// ----------------------------------------------------------------------------
package svdpi_pkg;

    localparam int MAX_ROWS_DEF = 16;
    localparam int MAX_COLS_DEF = 16;

    localparam int DATA_W = 32;   // Q16.16 word
    localparam int ACC_W  = 56;   // exact sum of up to 64 shifted products
    localparam int SIZE_W = 5;    // rows_used, cols_used, rank
    localparam int IDX_W  = 4;    // row / column index fields

    typedef enum logic [1:0] {
        OP_WR_U = 2'd0,
        OP_WR_V = 2'd1,
        OP_WR_W = 2'd2,
        OP_WR_B = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_ROWS    = 2'd0,
        CFG_COLS    = 2'd1,
        CFG_THR     = 2'd2,
        CFG_DEF_THR = 2'd3
    } t_cfg_idx;

    // divider result bundle
    typedef struct packed {
        logic              done;
        logic              sat;
        logic [DATA_W-1:0] quo;
    } t_div_res;

endpackage

### rtl/core/svdpi_div.sv
// ----------------------------------------------------------------------------
// svdpi_div
// Radix-2 restoring divider: signed accumulator over positive Q16.16 value,
// truncated toward zero, saturated to 32 bits. 32 steps from start to result;
// when the integer part overflows, the clipped result appears in the cycle after start.
// ----------------------------------------------------------------------------
module svdpi_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [svdpi_pkg::ACC_W-1:0]  i_num,
    input  logic [svdpi_pkg::DATA_W-1:0] i_den,
    output svdpi_pkg::t_div_res          o_res
);
    import svdpi_pkg::*;

    logic              r_busy, n_busy;
    logic [5:0]        r_cnt, n_cnt;
    logic              r_neg, n_neg;
    logic [DATA_W:0]   r_rem, n_rem;
    logic [DATA_W-1:0] r_q, n_q;
    logic [DATA_W-1:0] r_den, n_den;
    t_div_res          r_res, n_res;

    logic [ACC_W-1:0]  w_mag;
    logic [DATA_W:0]   w_trial;
    logic [DATA_W:0]   w_diff;

    assign w_mag   = i_num[ACC_W-1] ? (~i_num + ACC_W'(1)) : i_num;
    assign w_trial = {r_rem[DATA_W-1:0], r_q[DATA_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_rem  = r_rem;
        n_q    = r_q;
        n_den  = r_den;
        n_res  = r_res;
        n_res.done = 1'b0;
        if (i_start) begin
            n_neg = i_num[ACC_W-1];
            n_den = i_den;
            if (w_mag >= {{(ACC_W-DATA_W-16){1'b0}}, i_den, 16'b0}) begin
                // integer part does not fit: clip at once
                n_res.done = 1'b1;
                n_res.sat  = 1'b1;
                n_res.quo  = i_num[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                n_busy = 1'b1;
                n_cnt  = 6'd0;
                n_rem  = (DATA_W+1)'(w_mag[ACC_W-1:16]);
                n_q    = {w_mag[15:0], 16'b0};
            end
        end else if (r_busy) begin
            if (!w_diff[DATA_W]) begin
                n_rem = w_diff;
                n_q   = {r_q[DATA_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_q   = {r_q[DATA_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy     = 1'b0;
                n_res.done = 1'b1;
                if (r_neg) begin
                    n_res.sat = (n_q > 32'h8000_0000);
                    n_res.quo = n_res.sat ? 32'h8000_0000 : (~n_q + 32'd1);
                end else begin
                    n_res.sat = n_q[DATA_W-1];
                    n_res.quo = n_res.sat ? 32'h7FFF_FFFF : n_q;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_res.done <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_res.done <= n_res.done;
        end
        r_cnt     <= n_cnt;
        r_neg     <= n_neg;
        r_rem     <= n_rem;
        r_q       <= n_q;
        r_den     <= n_den;
        r_res.sat <= n_res.sat;
        r_res.quo <= n_res.quo;
    end

    assign o_res = r_res;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res.done |=> !r_res.done) else $error("divider done longer than one cycle");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start) else $error("divider restarted while busy");
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_cnt == 6'd31 |=> r_res.done) else $error("divider missed done");

endmodule

### rtl/core/svd_pseudo_inverse_solve.sv
// ----------------------------------------------------------------------------
// svd_pseudo_inverse_solve
// Least-squares solve x = V * diag(1/w) * U^T * b from loaded SVD factors.
// ----------------------------------------------------------------------------
// Load words (tuser = operation) write U, V, singular values w or b into
// on-chip RAMs, back to back while no solve runs. A b word with tlast set
// starts the solve: for each column j the block reads w_j, and when w_j
// exceeds the threshold runs m multiply-accumulates over U column j and b,
// then a 32-step radix-2 division, giving tmp_j; then for each j it runs n
// multiply-accumulates over row j of V and tmp and emits x_j. The MAC pipe
// issues one read per cycle and drains through its read and product
// registers. The input is not ready during a solve. Results leave through
// an output register, so a new word is taken while the last x still waits.
// Q16.16 products are floored by 16 bits and summed exactly; tmp and x
// saturate, and tuser flags a saturation of x_j or of any tmp of the run.
// Configuration writes are taken only while no solve runs and apply from the
// next solve.
// ----------------------------------------------------------------------------
module svd_pseudo_inverse_solve #(
    parameter int MAX_ROWS = svdpi_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = svdpi_pkg::MAX_COLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // load / rhs words
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // row_index[3:0], col_index[7:4], data_value[39:8]
    input  logic [1:0]  i_s_tuser,   // operation[1:0]
    input  logic        i_s_tlast,   // start_solve
    // solution words
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // solution_value[31:0], solution_index[35:32],
                                     // rank_count[40:36], zero pad
    output logic        o_m_tuser,   // saturated
    output logic        o_m_tlast,   // is_last
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import svdpi_pkg::*;

    localparam int MAXD = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int CW   = $clog2(MAXD + 1);
    localparam int UD   = MAX_ROWS * MAX_COLS;
    localparam int VD   = MAX_COLS * MAX_COLS;
    localparam int UAW  = (UD > 1) ? $clog2(UD) : 1;
    localparam int VAW  = (VD > 1) ? $clog2(VD) : 1;
    localparam int BAW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CAW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_WRD  = 7'b0000010,
        S_WCHK = 7'b0000100,
        S_UMAC = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_VMAC = 7'b0100000,
        S_XOUT = 7'b1000000
    } t_state;

    // storage
    logic [DATA_W-1:0] mem_u [UD];
    logic [DATA_W-1:0] mem_v [VD];
    logic [DATA_W-1:0] mem_w [MAX_COLS];
    logic [DATA_W-1:0] mem_b [MAX_ROWS];
    logic [DATA_W-1:0] mem_t [MAX_COLS];

    // configuration
    logic [SIZE_W-1:0] r_rows, r_cols;
    logic [31:0]       r_thr;
    logic [30:0]       r_dthr;

    // control
    t_state            r_state, n_state;
    logic [CW-1:0]     r_j, n_j;
    logic [CW-1:0]     r_iss, n_iss;
    logic [CW-1:0]     r_m, n_m, r_n, n_n;
    logic [SIZE_W-1:0] r_rank, n_rank;
    logic              r_tsat, n_tsat;
    logic              r_div_go, n_div_go;
    logic              r_rv, r_rlast, r_pv, r_plast;
    logic [ACC_W-1:0]  r_acc, n_acc;

    // read data and pipe
    logic [DATA_W-1:0] r_ud, r_vd, r_wd, r_bd, r_td;
    logic signed [63:0] r_prod;

    // output register
    logic              r_ov;
    logic [DATA_W-1:0] r_ox;
    logic [IDX_W-1:0]  r_oidx;
    logic [SIZE_W-1:0] r_orank;
    logic              r_osat, r_olast;

    t_div_res          w_div;
    logic              w_s_acc, w_issue, w_last_iss, w_mac_done, w_above, w_oload;
    logic [CW-1:0]     w_lim;
    logic [DATA_W-1:0] w_th;
    logic [DATA_W-1:0] w_fa, w_fb;
    logic [CW-1:0]     w_m_cl, w_n_cl;
    logic              w_xsat;
    logic [DATA_W-1:0] w_x;
    logic [IDX_W-1:0]  w_row, w_col;
    logic [DATA_W-1:0] w_val;
    t_op               w_op;
    logic              w_t_we;
    logic [DATA_W-1:0] w_t_wd;

    assign w_row = i_s_tdata[3:0];
    assign w_col = i_s_tdata[7:4];
    assign w_val = i_s_tdata[39:8];
    assign w_op  = t_op'(i_s_tuser);

    assign o_s_tready = (r_state == S_IDLE);
    assign w_s_acc    = i_s_tvalid && o_s_tready;
    // hold register writes off while a solve reads them
    assign o_cfg_ready = (r_state == S_IDLE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= SIZE_W'(16);
            r_cols <= SIZE_W'(16);
            r_thr  <= 32'hFFFF_FFFF;
            r_dthr <= 31'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ROWS:    r_rows <= i_cfg_data[SIZE_W-1:0];
                CFG_COLS:    r_cols <= i_cfg_data[SIZE_W-1:0];
                CFG_THR:     r_thr  <= i_cfg_data;
                CFG_DEF_THR: r_dthr <= i_cfg_data[30:0];
                default:     r_thr  <= r_thr;
            endcase
        end
    end

    // clamp sizes into 1..MAX
    assign w_m_cl = (r_rows == '0) ? CW'(1) :
                    (int'(r_rows) > MAX_ROWS) ? CW'(MAX_ROWS) : CW'(r_rows);
    assign w_n_cl = (r_cols == '0) ? CW'(1) :
                    (int'(r_cols) > MAX_COLS) ? CW'(MAX_COLS) : CW'(r_cols);

    assign w_th    = r_thr[31] ? {1'b0, r_dthr} : r_thr;
    assign w_above = $signed(r_wd) > $signed(w_th);

    // MAC issue control
    assign w_lim      = (r_state == S_UMAC) ? r_m : r_n;
    assign w_issue    = (r_state == S_UMAC || r_state == S_VMAC) && (r_iss < w_lim);
    assign w_last_iss = (r_iss == w_lim - CW'(1));
    assign w_mac_done = r_pv && r_plast;

    // RAM write from load words
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            unique case (w_op)
                OP_WR_U: if (int'(w_row) < MAX_ROWS && int'(w_col) < MAX_COLS)
                    mem_u[UAW'(int'(w_row) * MAX_COLS + int'(w_col))] <= w_val;
                OP_WR_V: if (int'(w_row) < MAX_COLS && int'(w_col) < MAX_COLS)
                    mem_v[VAW'(int'(w_row) * MAX_COLS + int'(w_col))] <= w_val;
                OP_WR_W: if (int'(w_col) < MAX_COLS)
                    mem_w[CAW'(w_col)] <= w_val;
                OP_WR_B: if (int'(w_row) < MAX_ROWS)
                    mem_b[BAW'(w_row)] <= w_val;
                default: ;
            endcase
        end
    end

    // RAM reads, registered
    always_ff @(posedge i_clk) begin
        r_wd <= mem_w[CAW'(r_j)];
        r_ud <= mem_u[UAW'(int'(r_iss) * MAX_COLS + int'(r_j))];
        r_bd <= mem_b[BAW'(r_iss)];
        r_vd <= mem_v[VAW'(int'(r_j) * MAX_COLS + int'(r_iss))];
        r_td <= mem_t[CAW'(r_iss)];
    end

    // tmp store
    assign w_t_we = (r_state == S_WCHK && !w_above) || (r_state == S_DIV && w_div.done);
    assign w_t_wd = (r_state == S_DIV) ? w_div.quo : '0;

    always_ff @(posedge i_clk) begin
        if (w_t_we) begin
            mem_t[CAW'(r_j)] <= w_t_wd;
        end
    end

    // product stage
    assign w_fa = (r_state == S_UMAC) ? r_ud : r_vd;
    assign w_fb = (r_state == S_UMAC) ? r_bd : r_td;

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(w_fa) * $signed(w_fb);
    end

    svdpi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_acc),
        .i_den   (r_wd),
        .o_res   (w_div)
    );

    // solution saturation
    assign w_xsat = ($signed(r_acc) > $signed(ACC_W'(32'sh7FFF_FFFF))) ||
                    ($signed(r_acc) < -$signed(ACC_W'(64'sh8000_0000)));
    assign w_x    = !w_xsat ? r_acc[DATA_W-1:0] :
                    (r_acc[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    assign w_oload = (r_state == S_XOUT) && (!r_ov || i_m_tready);

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_j      = r_j;
        n_iss    = w_issue ? r_iss + CW'(1) : r_iss;
        n_m      = r_m;
        n_n      = r_n;
        n_rank   = r_rank;
        n_tsat   = r_tsat;
        n_div_go = 1'b0;
        n_acc    = r_pv ? r_acc + ACC_W'($signed(r_prod[63:16])) : r_acc;
        unique case (r_state)
            S_IDLE: begin
                if (w_s_acc && i_s_tlast && w_op == OP_WR_B) begin
                    n_m     = w_m_cl;
                    n_n     = w_n_cl;
                    n_j     = '0;
                    n_rank  = '0;
                    n_tsat  = 1'b0;
                    n_state = S_WRD;
                end
            end
            S_WRD: n_state = S_WCHK;
            S_WCHK: begin
                n_iss = '0;
                n_acc = '0;
                if (w_above) begin
                    n_rank  = r_rank + SIZE_W'(1);
                    n_state = S_UMAC;
                end else if (r_j == r_n - CW'(1)) begin
                    n_j     = '0;
                    n_state = S_VMAC;
                end else begin
                    n_j     = r_j + CW'(1);
                    n_state = S_WRD;
                end
            end
            S_UMAC: begin
                if (w_mac_done) begin
                    n_div_go = 1'b1;
                    n_state  = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div.done) begin
                    n_tsat = r_tsat | w_div.sat;
                    n_iss  = '0;
                    n_acc  = '0;
                    if (r_j == r_n - CW'(1)) begin
                        n_j     = '0;
                        n_state = S_VMAC;
                    end else begin
                        n_j     = r_j + CW'(1);
                        n_state = S_WRD;
                    end
                end
            end
            S_VMAC: begin
                if (w_mac_done) n_state = S_XOUT;
            end
            S_XOUT: begin
                if (w_oload) begin
                    n_iss = '0;
                    n_acc = '0;
                    if (r_j == r_n - CW'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_j     = r_j + CW'(1);
                        n_state = S_VMAC;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_div_go <= 1'b0;
            r_rv     <= 1'b0;
            r_pv     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_div_go <= n_div_go;
            r_rv     <= w_issue;
            r_pv     <= r_rv;
            if (w_oload)         r_ov <= 1'b1;
            else if (i_m_tready) r_ov <= 1'b0;
        end
        r_j     <= n_j;
        r_iss   <= n_iss;
        r_m     <= n_m;
        r_n     <= n_n;
        r_rank  <= n_rank;
        r_tsat  <= n_tsat;
        r_acc   <= n_acc;
        r_rlast <= w_issue && w_last_iss;
        r_plast <= r_rlast;
        if (w_oload) begin
            r_ox    <= w_x;
            r_oidx  <= r_j[IDX_W-1:0];
            r_olast <= (r_j == r_n - CW'(1));
            r_orank <= (r_j == r_n - CW'(1)) ? r_rank : '0;
            r_osat  <= r_tsat | w_xsat;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {7'b0, r_orank, r_oidx, r_ox};
    assign o_m_tuser  = r_osat;
    assign o_m_tlast  = r_olast;

    a_mac_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (r_state == S_UMAC || r_state == S_VMAC))
        else $error("product outside a MAC phase");
    a_div_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> r_state == S_DIV) else $error("divider done outside divide");
    a_rank_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> r_rank <= SIZE_W'(r_n)) else $error("rank above n");
    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> r_j < r_n) else $error("column index past n");

endmodule

### tb/svd_pseudo_inverse_solve_checker.sv
// ----------------------------------------------------------------------------
// svd_pseudo_inverse_solve_checker
// Watches the load, solution and register channels of the SVD solver, keeps
// its own copy of the factor stores and registers, predicts every solution
// word and compares it field by field with what the block emits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svd_pseudo_inverse_solve_checker
    import svdpi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [47:0] i_m_tdata,
    input  logic        i_m_tuser,
    input  logic        i_m_tlast,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_pending,
    output int          o_fail_cnt
);

    typedef struct {
        logic [31:0] value;
        logic [3:0]  index;
        logic        last;
        logic [4:0]  rank;
        logic        sat;
    } t_solution;

    t_solution solution_q[$];

    logic [4:0]  rows_reg;
    logic [4:0]  cols_reg;
    logic [31:0] thr_reg;
    logic [30:0] def_thr_reg;

    logic signed [31:0] u_mem [16][16];
    logic signed [31:0] v_mem [16][16];
    logic signed [31:0] w_mem [16];
    logic signed [31:0] b_mem [16];

    // Q16.16 product, floored by 16 bits
    function automatic longint q16_mul(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> 16;
    endfunction

    function automatic longint clip32(longint v, inout bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // acc / w truncated toward zero; w is at least one LSB
    function automatic longint q16_div(longint acc, longint w, inout bit sat);
        bit              neg;
        longint unsigned mag, d, q, r, res;
        neg = acc < 0;
        mag = neg ? -acc : acc;
        d   = w;
        q   = mag / d;
        r   = mag % d;
        if (q >= 64'd65536) begin
            sat = 1'b1;
            return neg ? -64'sd2147483648 : 64'sd2147483647;
        end
        res = (q << 16) + (r << 16) / d;
        return clip32(neg ? -longint'(res) : longint'(res), sat);
    endfunction

    function automatic int clamp_size(logic [4:0] v);
        if (v == 0) return 1;
        if (v > 16) return 16;
        return int'(v);
    endfunction

    // Solve from the current stores and queue one word per solution element
    function automatic void predict_solution();
        int        m, n, rank;
        longint    th, acc;
        longint    tmp [16];
        bit        tmp_sat, sat;
        t_solution s;
        m       = clamp_size(rows_reg);
        n       = clamp_size(cols_reg);
        th      = $signed(thr_reg) < 0 ? longint'(def_thr_reg) : longint'($signed(thr_reg));
        rank    = 0;
        tmp_sat = 1'b0;
        for (int j = 0; j < n; j++) begin
            tmp[j] = 0;
            if (longint'(w_mem[j]) > th) begin
                rank++;
                acc = 0;
                for (int i = 0; i < m; i++)
                    acc += q16_mul(u_mem[i][j], b_mem[i]);
                tmp[j] = q16_div(acc, w_mem[j], tmp_sat);
            end
        end
        for (int j = 0; j < n; j++) begin
            acc = 0;
            sat = tmp_sat;
            for (int i = 0; i < n; i++)
                acc += q16_mul(v_mem[j][i], tmp[i]);
            s.value = 32'(clip32(acc, sat));
            s.index = 4'(j);
            s.last  = (j == n - 1);
            s.rank  = (j == n - 1) ? 5'(rank) : 5'd0;
            s.sat   = sat;
            solution_q.push_back(s);
        end
    endfunction

    always @(posedge i_clk) begin
        t_solution   want;
        logic [3:0]  row, col;
        logic [31:0] val;
        if (!i_rst_n) begin
            rows_reg    = 5'd16;
            cols_reg    = 5'd16;
            thr_reg     = 32'hFFFF_FFFF;
            def_thr_reg = '0;
            for (int i = 0; i < 16; i++) begin
                w_mem[i] = 0;
                b_mem[i] = 0;
                for (int k = 0; k < 16; k++) begin
                    u_mem[i][k] = 0;
                    v_mem[i][k] = 0;
                end
            end
            solution_q.delete();
            o_fail_cnt = 0;
        end else begin
            // check the emitted word against the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                if (solution_q.size() == 0) begin
                    o_fail_cnt++;
                    if (o_fail_cnt <= 10)
                        $display("%0t: unexpected solution word %h", $realtime, i_m_tdata);
                end else begin
                    want = solution_q.pop_front();
                    if (i_m_tdata[31:0] !== want.value || i_m_tdata[35:32] !== want.index ||
                        i_m_tdata[40:36] !== want.rank || i_m_tdata[47:41] !== '0 ||
                        i_m_tlast !== want.last || i_m_tuser !== want.sat) begin
                        o_fail_cnt++;
                        if (o_fail_cnt <= 10) begin
                            $write("%0t: x[%0d] exp val=%h rank=%0d last=%b sat=%b",
                                   $realtime, want.index, want.value, want.rank,
                                   want.last, want.sat);
                            $display(" | got val=%h idx=%0d rank=%0d last=%b sat=%b",
                                     i_m_tdata[31:0], i_m_tdata[35:32], i_m_tdata[40:36],
                                     i_m_tlast, i_m_tuser);
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_ROWS:    rows_reg    = i_cfg_data[4:0];
                    CFG_COLS:    cols_reg    = i_cfg_data[4:0];
                    CFG_THR:     thr_reg     = i_cfg_data;
                    CFG_DEF_THR: def_thr_reg = i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                row = i_s_tdata[3:0];
                col = i_s_tdata[7:4];
                val = i_s_tdata[39:8];
                case (t_op'(i_s_tuser))
                    OP_WR_U: u_mem[row][col] = val;
                    OP_WR_V: v_mem[row][col] = val;
                    OP_WR_W: w_mem[col]      = val;
                    OP_WR_B: begin
                        b_mem[row] = val;
                        if (i_s_tlast)
                            predict_solution();
                    end
                    default: ;
                endcase
            end
        end
        o_pending = solution_q.size();
    end

endmodule

### tb/svd_pseudo_inverse_solve_tb.sv
// ----------------------------------------------------------------------------
// svd_pseudo_inverse_solve_tb
// Loads SVD factors, singular values and right-hand sides into the solver,
// runs solves under several register settings and three idle patterns, and
// lets the checker compare every solution word with its prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svd_pseudo_inverse_solve_tb;
    import svdpi_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_WAIT  = 64;     // covers a load still in flight
    localparam int FILL        = 5;      // solves use at most FILL rows and columns

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    int pending;
    int fail_cnt;
    int send_idle;       // percent of cycles the load side holds off
    int recv_idle;       // percent of cycles the solution side stalls
    int cycles;

    svd_pseudo_inverse_solve dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    svd_pseudo_inverse_solve_checker checker_u (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .i_m_tlast  (m_tlast),
        .i_cfg_valid(cfg_valid),
        .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .o_pending  (pending),
        .o_fail_cnt (fail_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Stall the solution side at random; the rate follows the current phase
    always @(negedge i_clk)
        m_tready <= ($urandom_range(99) >= recv_idle);

    // Watchdog: end the run if the block hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offer one load word; hold it until the block takes it
    task automatic send_word(t_op op, logic [3:0] row, logic [3:0] col,
                             logic [31:0] val, logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {val, col, row};
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, drain all predicted words, then let the block settle
    task automatic quiesce();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    // Mostly modest Q16.16 values so results stay in range; some full-range
    function automatic logic [31:0] pick_value(t_op op);
        if ($urandom_range(3) == 0)
            return $urandom;
        if (op == OP_WR_W)
            return $urandom_range(1 << 18, 1 << 14);
        return $urandom_range(1 << 18, 0) - (1 << 17);
    endfunction

    // One well-formed run: a few factor updates, some b words, then the start
    task automatic solve_sequence();
        int   nload, nb;
        t_op  op;
        nload = $urandom_range(4);
        nb    = $urandom_range(2);
        for (int k = 0; k < nload; k++) begin
            op = t_op'($urandom_range(2));
            // start flag on a load is noise: the block must only store it
            send_word(op, 4'($urandom_range(15)), 4'($urandom_range(15)), pick_value(op),
                      $urandom_range(9) == 0);
        end
        for (int k = 0; k < nb; k++)
            send_word(OP_WR_B, 4'($urandom_range(15)), 4'($urandom_range(15)),
                      pick_value(OP_WR_B), 1'b0);
        send_word(OP_WR_B, 4'($urandom_range(15)), 4'($urandom_range(15)),
                  pick_value(OP_WR_B), 1'b1);
    endtask

    task automatic run_setting(logic [4:0] rows, logic [4:0] cols,
                               logic [31:0] thr, logic [30:0] def_thr);
        quiesce();
        write_reg(CFG_ROWS, 32'(rows));
        write_reg(CFG_COLS, 32'(cols));
        write_reg(CFG_THR, thr);
        write_reg(CFG_DEF_THR, {1'b0, def_thr});
        repeat (2) solve_sequence();
    endtask

    initial begin
        i_rst_n   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_WR_U;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ROWS;
        cfg_data  = '0;
        send_idle = 37;
        recv_idle = 79;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Fill the corner of each store that the solves read
        for (int r = 0; r < FILL; r++) begin
            for (int c = 0; c < FILL; c++) begin
                send_word(OP_WR_U, 4'(r), 4'(c), pick_value(OP_WR_U), 1'b0);
                send_word(OP_WR_V, 4'(r), 4'(c), pick_value(OP_WR_V), 1'b0);
            end
            send_word(OP_WR_W, 4'd0, 4'(r), pick_value(OP_WR_W), 1'b0);
            send_word(OP_WR_B, 4'(r), 4'd0, pick_value(OP_WR_B), 1'b0);
        end

        // Directed: reset thresholds, field extremes, start on a load
        quiesce();
        write_reg(CFG_ROWS, 32'(FILL));
        write_reg(CFG_COLS, 32'(FILL));
        send_word(OP_WR_B, 4'd0, 4'd0, 32'h0001_0000, 1'b1);
        send_word(OP_WR_U, 4'd4, 4'd4, 32'h7FFF_FFFF, 1'b1);
        send_word(OP_WR_V, 4'd4, 4'd0, 32'h8000_0000, 1'b1);
        send_word(OP_WR_W, 4'd0, 4'd4, 32'h0000_0001, 1'b0);
        send_word(OP_WR_W, 4'd4, 4'd3, 32'h8000_0000, 1'b0);
        send_word(OP_WR_B, 4'd4, 4'd15, 32'h7FFF_FFFF, 1'b1);
        send_word(OP_WR_B, 4'd0, 4'd15, 32'h8000_0000, 1'b1);
        send_word(OP_WR_W, 4'd15, 4'd4, 32'h0001_0000, 1'b0);
        send_word(OP_WR_W, 4'd0, 4'd3, 32'h0002_0000, 1'b0);
        send_word(OP_WR_B, 4'd4, 4'd0, 32'h0000_0000, 1'b1);

        // Size clamping: zero counts as one
        quiesce();
        write_reg(CFG_ROWS, 32'd0);
        write_reg(CFG_COLS, 32'd0);
        write_reg(CFG_THR, 32'h0000_0000);
        write_reg(CFG_DEF_THR, 32'h7FFF_FFFF);
        send_word(OP_WR_B, 4'd0, 4'd0, 32'hFFFF_0000, 1'b1);
        quiesce();
        write_reg(CFG_ROWS, 32'd3);
        write_reg(CFG_COLS, 32'd0);
        write_reg(CFG_THR, 32'h8000_0000);
        send_word(OP_WR_B, 4'd3, 4'd0, 32'h0004_0000, 1'b1);

        // Random part, sender idle 37 / receiver idle 79
        run_setting(5'd5, 5'd5, 32'hFFFF_FFFF, 31'd0);
        run_setting(5'd0, 5'd4, 32'h0000_0000, 31'h7FFF_FFFF);
        run_setting(5'd3, 5'd0, 32'hFFFF_FFFF, 31'h7FFF_FFFF);

        // Swap the idle rates
        send_idle = 79;
        recv_idle = 37;
        run_setting(5'd4, 5'd3, 32'h8000_0000, 31'h0001_0000);
        run_setting(5'd5, 5'd5, 32'h7FFF_FFFF, 31'd0);
        run_setting(5'd2, 5'd5, 32'h0000_4000, 31'd0);

        // No idling at all
        send_idle = 0;
        recv_idle = 0;
        run_setting(5'd1, 5'd1, 32'hFFFF_FFFF, 31'd123);
        run_setting(5'd5, 5'd2, 32'hFFFF_FFFB, 31'h0000_8000);
        run_setting(5'd4, 5'd5, 32'h0000_0000, 31'd0);

        quiesce();
        if (fail_cnt == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
